### src/cxrd_pkg.sv
// Package for the chunk XOR-rotate descrambler.
// Holds field widths, mode codes, the key table and the rotate helpers.
// No dependencies.
package cxrd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 11;
    localparam int WORD_W      = 16;
    localparam int SLOT_W      = 5;
    localparam int KEY_LENGTH  = 17;
    localparam int MAX_CHUNK   = 2047;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int MODE_W      = 2;
    localparam logic REG_MODE  = 1'b0;   // register index, paddr[2]

    // scramble_mode codes
    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHAIN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_KEY_ALT = 2'd3;  // same as MODE_KEY

    localparam logic [WORD_W-1:0] CHAIN_SEED = 16'hDB24;

    localparam logic [BYTE_W-1:0] KEY_TABLE [KEY_LENGTH] = '{
        8'h8C, 8'h53, 8'hB8, 8'hA7, 8'h9E, 8'h0F, 8'h0A, 8'hCB, 8'h28,
        8'h62, 8'h2D, 8'h50, 8'h7E, 8'h05, 8'h3D, 8'h4E, 8'h35
    };

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    // Key byte for a slot; an out-of-range slot falls back to slot zero
    function automatic logic [BYTE_W-1:0] key_byte(input logic [SLOT_W-1:0] slot);
        logic [BYTE_W-1:0] k;
        if (slot < SLOT_W'(KEY_LENGTH))
        begin
            k = KEY_TABLE[slot];
        end
        else
        begin
            k = KEY_TABLE[0];
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rotr16(input logic [WORD_W-1:0] w,
                                                 input logic [3:0] r);
        logic [2*WORD_W-1:0] d;
        d = {w, w} >> r;
        return d[WORD_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] rotr8(input logic [BYTE_W-1:0] b,
                                                input logic [2:0] r);
        logic [2*BYTE_W-1:0] d;
        d = {b, b} >> r;
        return d[BYTE_W-1:0];
    endfunction

endpackage

### src/chunk_xor_rotate_descrambler_unit.sv
// Chunk XOR-rotate descrambler, top level.
// Depends on cxrd_pkg (widths, mode codes, key table, rotate functions).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   in       | sink      | in_valid/in_stall  | cipher_byte, chunk_length
//   out      | source    | out_valid/out_stall| plain_byte, chunk_end
//   apb      | slave     | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// One input byte per cycle while in_stall is low; its results enter the result
// queue at the accepting edge and are output from its head. Outside pass mode
// a word's second byte pushes two, a non-final first byte none; others push one.
// in_stall rises when the four-entry result queue has fewer than two free slots.
// Reset clears the counters, loads the chain seed and empties the queue.
module chunk_xor_rotate_descrambler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // input transfer
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cxrd_pkg::BYTE_W-1:0]       cipher_byte,
    input  logic [cxrd_pkg::LEN_W-1:0]        chunk_length,
    // result transfer
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cxrd_pkg::BYTE_W-1:0]       plain_byte,
    output logic                              chunk_end,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cxrd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cxrd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cxrd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import cxrd_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [LEN_W-1:0]   pos_reg,      pos_next;
    logic [SLOT_W-1:0]  slot_reg,     slot_next;
    logic [BYTE_W-1:0]  held_reg,     held_next;
    logic [WORD_W-1:0]  chain_reg,    chain_next;
    logic [2:0]         lrot_reg,     lrot_next;

    result_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg,   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,    count_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               cfg_write;
    logic               key_on;
    logic               chain_on;
    logic [LEN_W-1:0]   len_eff;
    logic               is_final;
    logic [WORD_W-1:0]  chain_cur;
    logic [2:0]         lrot_cur;
    logic [BYTE_W-1:0]  key_mix;
    logic [BYTE_W-1:0]  byte_k;
    logic [BYTE_W-1:0]  dl;
    logic [BYTE_W-1:0]  cl;
    logic [WORD_W-1:0]  pair_word;
    logic [WORD_W-1:0]  word_out;
    logic [1:0]         push_n;
    result_t            push0;
    result_t            push1;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MODE)
        begin
            prdata[MODE_W-1:0] = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PASS;
        end
        else if (cfg_write && (paddr[2] == REG_MODE))
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // Handshakes
    assign in_stall  = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && !out_stall;

    // Per-byte datapath
    assign key_on   = (mode_reg == MODE_KEY) || (mode_reg == MODE_KEY_ALT);
    assign chain_on = (mode_reg != MODE_PASS);
    assign len_eff  = (chunk_length == '0) ? LEN_W'(1) : chunk_length;
    assign is_final = ({1'b0, pos_reg} + (LEN_W+1)'(1)) >= {1'b0, len_eff};

    // chain and last rotate restart at the head of a chunk
    assign chain_cur = (pos_reg == '0) ? CHAIN_SEED : chain_reg;
    assign lrot_cur  = (pos_reg == '0) ? 3'd0 : lrot_reg;

    assign key_mix   = key_byte(slot_reg) + (len_eff[BYTE_W-1:0] - pos_reg[BYTE_W-1:0]);
    assign byte_k    = key_on ? (cipher_byte ^ key_mix) : cipher_byte;

    // remaining word count and rotate amount
    assign dl        = len_eff[BYTE_W:1] - pos_reg[BYTE_W:1];
    assign cl        = chain_cur[BYTE_W-1:0] + dl;
    assign pair_word = {byte_k, held_reg};
    assign word_out  = rotr16(pair_word, cl[3:0]) ^ {dl, dl} ^ chain_cur;

    always_comb
    begin
        held_next  = held_reg;
        chain_next = chain_cur;
        lrot_next  = lrot_cur;
        push_n     = 2'd0;
        push0      = '{data: byte_k, last: is_final};
        push1      = '{data: word_out[WORD_W-1:BYTE_W], last: is_final};

        priority if (!chain_on)
        begin
            push_n = 2'd1;
        end
        else if (!pos_reg[0])
        begin
            if (is_final)
            begin
                // trailing odd byte
                push0.data = rotr8(byte_k ^ chain_cur[BYTE_W-1:0], lrot_cur);
                push_n     = 2'd1;
            end
            else
            begin
                held_next = byte_k;
            end
        end
        else
        begin
            push0      = '{data: word_out[BYTE_W-1:0], last: 1'b0};
            push_n     = 2'd2;
            chain_next = pair_word;
            lrot_next  = cl[2:0];
        end

        if (is_final)
        begin
            pos_next  = '0;
            slot_next = '0;
        end
        else
        begin
            pos_next  = pos_reg + LEN_W'(1);
            slot_next = (slot_reg == SLOT_W'(KEY_LENGTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            slot_reg  <= '0;
            held_reg  <= '0;
            chain_reg <= CHAIN_SEED;
            lrot_reg  <= '0;
        end
        else if (in_xfer)
        begin
            pos_reg   <= pos_next;
            slot_reg  <= slot_next;
            held_reg  <= held_next;
            chain_reg <= chain_next;
            lrot_reg  <= lrot_next;
        end
    end

    // Result queue bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
            count_next  = count_next + CNT_W'(push_n);
        end
        if (out_xfer)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: up to two entries written per transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer && (push_n != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (in_xfer && (push_n == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    assign plain_byte = fifo_mem[rd_ptr_reg].data;
    assign chunk_end  = fifo_mem[rd_ptr_reg].last;

`ifndef SYNTHESIS
    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // position stays inside the longest chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < LEN_W'(MAX_CHUNK))
        else $error("byte position out of range");

    // key slot stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_W'(KEY_LENGTH))
        else $error("key slot out of range");

    // a final byte rewinds both counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_final) |=> (pos_reg == '0) && (slot_reg == '0))
        else $error("counters not cleared at chunk end");

    // a non-final first byte of a word in a chain mode produces nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && chain_on && !pos_reg[0] && !is_final) |=> $stable(count_reg) || $past(out_xfer))
        else $error("unexpected result for held byte");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for chunk_xor_rotate_descrambler_unit.
// Drives byte transfers and mode register writes, predicts every plain byte
// with its own descrambler model. Depends on cxrd_pkg and the unit under test.
`timescale 1ns / 1ps

module testbench;
    import cxrd_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int IDLE_TAIL     = 4;    // result lands in queue, then shows on the output
    localparam int END_TAIL      = 12;
    localparam int RANDOM_BYTES  = 430;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};

    // Key bytes, in slot order
    localparam logic [7:0] DESCR_KEY [KEY_LENGTH] = '{
        8'h8C, 8'h53, 8'hB8, 8'hA7, 8'h9E, 8'h0F, 8'h0A, 8'hCB, 8'h28,
        8'h62, 8'h2D, 8'h50, 8'h7E, 8'h05, 8'h3D, 8'h4E, 8'h35
    };

    typedef struct {
        logic [7:0] data;
        logic       end_flag;
    } plain_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_regime_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     cipher_byte = '0;
    logic [LEN_W-1:0]      chunk_length = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     plain_byte;
    logic                  chunk_end;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic [MODE_W-1:0] sel_mode = MODE_PASS;
    int unsigned       pos_in_chunk = 0;
    int unsigned       key_idx = 0;
    logic [7:0]        pending_low = '0;
    logic [15:0]       chain_val = CHAIN_SEED;
    logic [7:0]        prev_rot = '0;

    plain_t        plain_expected[$];
    int            mismatch_count = 0;
    int            bytes_sent = 0;
    int            burst_left = 0;
    stall_regime_t stall_regime = STALL_NONE;
    int            regime_left = 0;

    chunk_xor_rotate_descrambler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cipher_byte  (cipher_byte),
        .chunk_length (chunk_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_byte   (plain_byte),
        .chunk_end    (chunk_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Descramble one accepted byte and queue the plain bytes it releases
    function automatic void predict_plain(input logic [7:0] cb, input logic [10:0] cl);
        int unsigned len_eff;
        logic        is_final;
        logic [7:0]  b;
        logic [7:0]  t;
        logic [7:0]  dl;
        logic [7:0]  cnt_rot;
        logic [2:0]  sh8;
        logic [3:0]  sh16;
        logic [15:0] w;
        logic [15:0] a;
        len_eff  = (cl == 0) ? 1 : cl;
        is_final = (pos_in_chunk + 1 >= len_eff);
        b        = cb;
        if (pos_in_chunk == 0)
        begin
            chain_val = CHAIN_SEED;
            prev_rot  = '0;
        end
        if (sel_mode == MODE_KEY || sel_mode == MODE_KEY_ALT)
        begin
            b = b ^ 8'(DESCR_KEY[(key_idx < KEY_LENGTH) ? key_idx : 0]
                       + (len_eff - pos_in_chunk));
        end
        if (sel_mode == MODE_PASS)
        begin
            plain_expected.push_back('{b, is_final});
        end
        else if (pos_in_chunk[0] == 1'b0)
        begin
            if (is_final)
            begin
                // trailing odd byte
                t   = b ^ chain_val[7:0];
                sh8 = prev_rot[2:0];
                t   = (t >> sh8) | (t << (8 - sh8));
                plain_expected.push_back('{t, 1'b1});
            end
            else
            begin
                pending_low = b;
            end
        end
        else
        begin
            w         = {b, pending_low};
            dl        = 8'((len_eff >> 1) - (pos_in_chunk >> 1));
            cnt_rot   = chain_val[7:0] + dl;
            sh16      = cnt_rot[3:0];
            a         = (w >> sh16) | (w << (16 - sh16));
            a         = a ^ {dl, dl} ^ chain_val;
            chain_val = w;
            prev_rot  = cnt_rot;
            plain_expected.push_back('{a[7:0], 1'b0});
            plain_expected.push_back('{a[15:8], is_final});
        end
        if (is_final)
        begin
            pos_in_chunk = 0;
            key_idx      = 0;
        end
        else
        begin
            pos_in_chunk = (pos_in_chunk + 1) & 32'h7FF;
            key_idx      = (key_idx + 1 >= KEY_LENGTH) ? 0 : key_idx + 1;
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Receiver stall pattern, switching to a random regime when its count runs out
    always @(negedge clk)
    begin
        if (regime_left == 0)
        begin
            stall_regime <= stall_regime_t'($urandom_range(0, 3));
            regime_left  <= $urandom_range(16, 96);
        end
        else
        begin
            regime_left <= regime_left - 1;
        end
        case (stall_regime)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (regime_left % 8 < 3);
        endcase
    end

    // Result checker: every output transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (plain_expected.size() == 0)
            begin
                note_failure($sformatf("unexpected result data=%02h end=%0b",
                                       plain_byte, chunk_end));
            end
            else
            begin
                if (plain_byte !== plain_expected[0].data)
                begin
                    note_failure($sformatf("plain_byte expected %02h got %02h",
                                           plain_expected[0].data, plain_byte));
                end
                if (chunk_end !== plain_expected[0].end_flag)
                begin
                    note_failure($sformatf("chunk_end expected %0b got %0b",
                                           plain_expected[0].end_flag, chunk_end));
                end
                void'(plain_expected.pop_front());
            end
        end
    end

    // One byte transfer, with bursts and random gaps ahead of it
    task automatic send_byte(input logic [7:0] cb, input logic [10:0] cl);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        cipher_byte  <= cb;
        chunk_length <= cl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_plain(cb, cl);
        bytes_sent++;
    endtask

    // Hold off input until every expected byte is out and the unit is quiet
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (plain_expected.size() != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    // Mode register write followed by a read back
    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= APB_DATA_W'(m);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sel_mode = m;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== APB_DATA_W'(m))
        begin
            note_failure($sformatf("mode read back expected %0d got %0h", m, prdata));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return MODE_PASS;
        end
        else if (r <= 3)
        begin
            return MODE_CHAIN;
        end
        else if (r <= 6)
        begin
            return MODE_KEY;
        end
        return MODE_KEY_ALT;
    endfunction

    // Pass through: extreme bytes, zero length treated as one
    task automatic test_pass_through();
        wait_idle();
        write_mode(MODE_PASS);
        send_byte(8'h00, 11'd1);
        send_byte(8'hFF, 11'd0);
        send_byte(8'h5A, 11'd2047);
        send_byte(8'hA5, 11'd1);
    endtask

    // Word chain: odd chunk with trailing byte, then an even chunk
    task automatic test_word_chain();
        wait_idle();
        write_mode(MODE_CHAIN);
        send_byte(8'hFF, 11'd3);
        send_byte(8'h00, 11'd3);
        send_byte(8'hA5, 11'd3);
        send_byte(8'h12, 11'd2);
        send_byte(8'h34, 11'd2);
    endtask

    // Key XOR modes, plus chunks that end early when the length shrinks
    task automatic test_key_chain();
        int i;
        wait_idle();
        write_mode(MODE_KEY);
        for (i = 0; i < 5; i++)
        begin
            send_byte(8'($urandom), 11'd5);
        end
        send_byte(8'hC3, 11'd1);
        wait_idle();
        write_mode(MODE_KEY_ALT);
        send_byte(8'hFF, 11'd2047);
        send_byte(8'h00, 11'd2047);
        send_byte(8'h81, 11'd1);    // position past length, even: trailing byte
        send_byte(8'h7E, 11'd2047);
        send_byte(8'hE7, 11'd0);    // shrinks on the odd byte of a word
    endtask

    // Mode changes inside a chunk: held low byte dropped by a pass-through byte
    task automatic test_mode_switch_mid_chunk();
        wait_idle();
        write_mode(MODE_CHAIN);
        send_byte(8'h3C, 11'd4);
        wait_idle();
        write_mode(MODE_PASS);
        send_byte(8'hC3, 11'd4);
        wait_idle();
        write_mode(MODE_KEY);
        send_byte(8'h96, 11'd4);
        send_byte(8'h69, 11'd4);
    endtask

    // Random chunks: mostly well formed, some cut short, some noise
    task automatic test_random_chunks();
        int          kind;
        int          n;
        int          i;
        logic [10:0] len;
        while (bytes_sent < RANDOM_BYTES + 20)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_idle();
                write_mode(pick_mode());
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                wait_idle();
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                len = 11'($urandom_range(1, 40));
                for (i = 0; i < len; i++)
                begin
                    send_byte(8'($urandom), len);
                end
            end
            else if (kind == 6 || kind == 7)
            begin
                // long chunk header, ended early by a shrinking length
                len = ($urandom_range(0, 3) == 0) ? 11'd2047 : 11'($urandom_range(41, 2047));
                n   = $urandom_range(1, 30);
                for (i = 0; i < n - 1; i++)
                begin
                    send_byte(8'($urandom), len);
                end
                send_byte(8'($urandom), 11'($urandom_range(0, n)));
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 16);
                for (i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), 11'($urandom_range(0, 2047)));
                end
            end
            else
            begin
                // mode switch somewhere inside a chunk
                len = 11'($urandom_range(2, 30));
                n   = $urandom_range(1, len - 1);
                for (i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), len);
                end
                wait_idle();
                write_mode(pick_mode());
                for (i = n; i < len; i++)
                begin
                    send_byte(8'($urandom), len);
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pass_through();
        test_word_chain();
        test_key_chain();
        test_mode_switch_mid_chunk();
        test_random_chunks();
        wait_idle();
        repeat (END_TAIL) @(posedge clk);
        if (mismatch_count == 0 && plain_expected.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
src/cxrd_pkg.sv
src/chunk_xor_rotate_descrambler_unit.sv
test/testbench.sv
